/* design/lavm_pkg.sv */
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared widths, latencies and payload types of the look-at pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

    localparam int AXIS_W    = 32;
    localparam int SHIFT_W   = 48;
    localparam int CROSS_W   = 63;
    localparam int NORM_LAT  = 69;
    localparam int CROSS_LAT = 2;
    localparam int XLATE_LAT = 5;

    localparam logic [30:0] Q_ONE = 31'h4000_0000;

    localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = 48'sh8000_0000_0000;

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef t_axis [2:0] t_vec3;

    typedef struct packed {
        logic [2:0][29:0] m;
        logic [2:0]       neg;
        logic             zero;
    } t_nside;

endpackage

/* design/lavm_delay.sv */
// ----------------------------------------------------------------------------
// Delay line
// Fixed-length register line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module lavm_delay #(
    parameter int W     = 32,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

/* design/lavm_norm.sv */
// ----------------------------------------------------------------------------
// Vector normaliser
// Scales a signed 3-vector to a Q2.30 unit vector: shift, square sum,
// bit-per-stage square root, bit-per-stage rounded division.
// ----------------------------------------------------------------------------
module lavm_norm import lavm_pkg::*; #(
    parameter int IN_W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2:0][IN_W-1:0]  i_c,
    output t_vec3                 o_v
);

    localparam int G  = (IN_W + 7) / 8;
    localparam int OW = G * 8;
    localparam int PB = $clog2(OW);
    localparam int EW = IN_W + 29;

    logic [2:0][IN_W-1:0] r1_mag;
    logic [2:0]           r1_neg;
    logic [OW-1:0]        w_or;
    logic [G-1:0]         n_gnz;
    logic [G-1:0][2:0]    n_gpos;
    logic [G-1:0]         r2_gnz;
    logic [G-1:0][2:0]    r2_gpos;
    logic [2:0][IN_W-1:0] r2_mag;
    logic [2:0]           r2_neg;
    logic [PB-1:0]        n_pos;
    logic                 n_nz;
    logic [PB-1:0]        r3_pos;
    logic                 r3_nz;
    logic [2:0][IN_W-1:0] r3_mag;
    logic [2:0]           r3_neg;
    logic [EW-1:0]        w_ext;
    logic [2:0][29:0]     w_m;
    t_nside               r4_sd;
    logic [2:0][59:0]     r5_sq;
    t_nside               r5_sd;
    logic [61:0]          r6_s;
    t_nside               r6_sd;

    logic [61:0]          w_sq_s    [0:30];
    logic [30:0]          w_sq_root [0:30];
    logic [32:0]          w_sq_rem  [0:30];
    t_nside               w_sq_sd   [0:30];
    logic [61:0]          r_sq_s    [1:31];
    logic [30:0]          r_sq_root [1:31];
    logic [32:0]          r_sq_rem  [1:31];
    t_nside               r_sq_sd   [1:31];

    logic [2:0][30:0]     w_dv_rem  [0:30];
    logic [2:0][30:0]     w_dv_q    [0:30];
    logic [30:0]          w_dv_r    [0:30];
    t_nside               w_dv_sd   [0:30];
    logic [2:0][30:0]     r_dv_rem  [1:31];
    logic [2:0][30:0]     r_dv_q    [1:31];
    logic [30:0]          r_dv_r    [1:31];
    t_nside               r_dv_sd   [1:31];

    t_vec3                n_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= i_c[i][IN_W-1];
                r1_mag[i] <= i_c[i][IN_W-1] ? IN_W'(~i_c[i] + IN_W'(1)) : i_c[i];
            end
        end
    end

    assign w_or = OW'(r1_mag[0] | r1_mag[1] | r1_mag[2]);

    always_comb begin
        for (int g = 0; g < G; g++) begin
            n_gnz[g]  = |w_or[g*8 +: 8];
            n_gpos[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (w_or[g*8+b]) begin
                    n_gpos[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_gnz  <= n_gnz;
            r2_gpos <= n_gpos;
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
        end
    end

    always_comb begin
        n_pos = '0;
        n_nz  = 1'b0;
        for (int g = 0; g < G; g++) begin
            if (r2_gnz[g]) begin
                n_nz  = 1'b1;
                n_pos = PB'(g * 8 + int'(r2_gpos[g]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pos <= n_pos;
            r3_nz  <= n_nz;
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
        end
    end

    always_comb begin
        w_ext = '0;
        for (int i = 0; i < 3; i++) begin
            w_ext  = EW'(r3_mag[i]) << 29;
            w_ext  = w_ext >> r3_pos;
            w_m[i] = w_ext[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sd.m    <= w_m;
            r4_sd.neg  <= r3_neg;
            r4_sd.zero <= !r3_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_sq[i] <= 60'(r4_sd.m[i]) * 60'(r4_sd.m[i]);
            end
            r5_sd <= r4_sd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_s  <= 62'(r5_sq[0]) + 62'(r5_sq[1]) + 62'(r5_sq[2]);
            r6_sd <= r5_sd;
        end
    end

    for (genvar k = 0; k < 31; k++) begin : g_sqrt
        logic [34:0] cur;
        logic [34:0] trial;
        logic [34:0] diff;

        if (k == 0) begin : g_first
            assign w_sq_s[k]    = r6_s;
            assign w_sq_root[k] = '0;
            assign w_sq_rem[k]  = '0;
            assign w_sq_sd[k]   = r6_sd;
        end else begin : g_rest
            assign w_sq_s[k]    = r_sq_s[k];
            assign w_sq_root[k] = r_sq_root[k];
            assign w_sq_rem[k]  = r_sq_rem[k];
            assign w_sq_sd[k]   = r_sq_sd[k];
        end

        assign cur   = {w_sq_rem[k], w_sq_s[k][2*(30-k)+1 -: 2]};
        assign trial = {2'b00, w_sq_root[k], 2'b01};
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_s[k+1]  <= w_sq_s[k];
                r_sq_sd[k+1] <= w_sq_sd[k];
                if (cur >= trial) begin
                    r_sq_rem[k+1]  <= diff[32:0];
                    r_sq_root[k+1] <= {w_sq_root[k][29:0], 1'b1};
                end else begin
                    r_sq_rem[k+1]  <= cur[32:0];
                    r_sq_root[k+1] <= {w_sq_root[k][29:0], 1'b0};
                end
            end
        end
    end

    for (genvar k = 0; k < 31; k++) begin : g_div
        logic [2:0]       nb;
        logic [2:0][30:0] n_rem;
        logic [2:0][30:0] n_q;

        if (k == 0) begin : g_first
            assign w_dv_rem[k] = {{2'b00, r_sq_sd[31].m[2][29:1]},
                                  {2'b00, r_sq_sd[31].m[1][29:1]},
                                  {2'b00, r_sq_sd[31].m[0][29:1]}};
            assign w_dv_q[k]   = '0;
            assign w_dv_r[k]   = r_sq_root[31];
            assign w_dv_sd[k]  = r_sq_sd[31];
            assign nb = {w_dv_sd[k].m[2][0], w_dv_sd[k].m[1][0], w_dv_sd[k].m[0][0]};
        end else begin : g_rest
            assign w_dv_rem[k] = r_dv_rem[k];
            assign w_dv_q[k]   = r_dv_q[k];
            assign w_dv_r[k]   = r_dv_r[k];
            assign w_dv_sd[k]  = r_dv_sd[k];
            assign nb = {3{w_dv_r[k][31-k]}};
        end

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                logic [31:0] t;
                logic [31:0] d;
                t = {w_dv_rem[k][i], nb[i]};
                d = t - {1'b0, w_dv_r[k]};
                if (t >= {1'b0, w_dv_r[k]}) begin
                    n_rem[i] = d[30:0];
                    n_q[i]   = {w_dv_q[k][i][29:0], 1'b1};
                end else begin
                    n_rem[i] = t[30:0];
                    n_q[i]   = {w_dv_q[k][i][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_rem[k+1] <= n_rem;
                r_dv_q[k+1]   <= n_q;
                r_dv_r[k+1]   <= w_dv_r[k];
                r_dv_sd[k+1]  <= w_dv_sd[k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [30:0] q;
            q = r_dv_q[31][i];
            if (q > Q_ONE) begin
                q = Q_ONE;
            end
            if (r_dv_sd[31].zero) begin
                n_v[i] = '0;
            end else if (r_dv_sd[31].neg[i]) begin
                n_v[i] = -$signed({1'b0, q});
            end else begin
                n_v[i] = $signed({1'b0, q});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_v <= n_v;
        end
    end

endmodule

/* design/lavm_cross.sv */
// ----------------------------------------------------------------------------
// Cross product
// Exact cross product of two Q2.30 vectors, products then differences.
// ----------------------------------------------------------------------------
module lavm_cross import lavm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_vec3                   i_a,
    input  t_vec3                   i_b,
    output logic [2:0][CROSS_W-1:0] o_c
);

    logic signed [63:0] r_p [0:5];
    logic signed [63:0] w_d [0:2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= 64'(i_a[1]) * 64'(i_b[2]);
            r_p[1] <= 64'(i_a[2]) * 64'(i_b[1]);
            r_p[2] <= 64'(i_a[2]) * 64'(i_b[0]);
            r_p[3] <= 64'(i_a[0]) * 64'(i_b[2]);
            r_p[4] <= 64'(i_a[0]) * 64'(i_b[1]);
            r_p[5] <= 64'(i_a[1]) * 64'(i_b[0]);
        end
    end

    assign w_d[0] = r_p[0] - r_p[1];
    assign w_d[1] = r_p[2] - r_p[3];
    assign w_d[2] = r_p[4] - r_p[5];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                o_c[i] <= w_d[i][CROSS_W-1:0];
            end
        end
    end

endmodule

/* design/lavm_xlate.sv */
// ----------------------------------------------------------------------------
// Translation term
// Negated, rounded and saturated dot product of one axis with the position.
// ----------------------------------------------------------------------------
module lavm_xlate import lavm_pkg::*; #(
    parameter int CW = 32
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  t_vec3                       i_a,
    input  logic [2:0][CW-1:0]          i_p,
    output logic signed [SHIFT_W-1:0]   o_t
);

    localparam int LO = CW / 2;
    localparam int HI = CW - LO;
    localparam int PW = AXIS_W + CW;
    localparam int SW = PW + 2;
    localparam int RW = SW - 30;
    localparam int XW = (RW + 1 > SHIFT_W + 1) ? RW + 1 : SHIFT_W + 1;

    logic signed [AXIS_W+HI-1:0]   r_ph   [0:2];
    logic signed [AXIS_W+LO:0]     r_pl   [0:2];
    logic signed [PW-1:0]          r_prod [0:2];
    logic signed [SW-1:0]          r_sum;
    logic signed [SW-1:0]          w_rnd;
    logic signed [RW-1:0]          r_rnd;
    logic signed [XW-1:0]          w_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ph[i] <= (AXIS_W+HI)'(i_a[i]) * (AXIS_W+HI)'($signed(i_p[i][CW-1:LO]));
                r_pl[i] <= (AXIS_W+LO+1)'(i_a[i])
                           * (AXIS_W+LO+1)'($signed({1'b0, i_p[i][LO-1:0]}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= (PW'(r_ph[i]) <<< LO) + PW'(r_pl[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]);
        end
    end

    assign w_rnd = r_sum + (SW'(1) <<< 29);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rnd <= w_rnd[SW-1:30];
        end
    end

    assign w_neg = -XW'(r_rnd);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_neg > XW'(SHIFT_MAX)) begin
                o_t <= SHIFT_MAX;
            end else if (w_neg < XW'(SHIFT_MIN)) begin
                o_t <= SHIFT_MIN;
            end else begin
                o_t <= w_neg[SHIFT_W-1:0];
            end
        end
    end

endmodule

/* design/look_at_view_matrix_unit.sv */
// Throughput: one item per cycle; the whole pipeline holds while the result stalls.
// Each of the four normalisers runs a 31-step square root and a 31-step divide.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// Look-at view matrix unit
// Builds left, camera-up and forward axes plus translations for each item.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit import lavm_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, upref_x, upref_y, upref_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // left_x/y/z, camup_x/y/z, forward_x/y/z, shift_left, shift_up, shift_forward
    output logic [9*AXIS_W+3*SHIFT_W-1:0] m_axis_tdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int TOT = 1 + 3*NORM_LAT + 2*CROSS_LAT + XLATE_LAT;
    localparam int D1  = CROSS_LAT + NORM_LAT;
    localparam int DE  = 3*NORM_LAT + 2*CROSS_LAT;

    logic                     w_adv;
    logic [TOT-1:0]           r_vld;
    logic [2:0][CW-1:0]       r_eye;
    logic [2:0][CW:0]         r_d;
    logic [2:0][CW-1:0]       r_up;
    t_vec3                    w_upn;
    t_vec3                    w_fw;
    t_vec3                    w_fw_a;
    t_vec3                    w_fw_b;
    t_vec3                    w_fw_o;
    logic [2:0][CROSS_W-1:0]  w_cl;
    logic [2:0][CROSS_W-1:0]  w_cu;
    t_vec3                    w_lf;
    t_vec3                    w_lf_b;
    t_vec3                    w_lf_o;
    t_vec3                    w_cu2;
    t_vec3                    w_cu_o;
    logic [2:0][CW-1:0]       w_eye_b;
    logic signed [SHIFT_W-1:0] w_sh_lf;
    logic signed [SHIFT_W-1:0] w_sh_cu;
    logic signed [SHIFT_W-1:0] w_sh_fw;

    assign w_adv         = !r_vld[TOT-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[TOT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[TOT-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_eye[i] <= s_axis_tdata[i*CW +: CW];
                r_up[i]  <= s_axis_tdata[(6+i)*CW +: CW];
                r_d[i]   <= (CW+1)'($signed(s_axis_tdata[i*CW +: CW]))
                            - (CW+1)'($signed(s_axis_tdata[(3+i)*CW +: CW]));
            end
        end
    end

    lavm_norm #(.IN_W(CW)) u_norm_up (
        .i_clk(i_clk), .i_en(w_adv), .i_c(r_up), .o_v(w_upn)
    );

    lavm_norm #(.IN_W(CW+1)) u_norm_fw (
        .i_clk(i_clk), .i_en(w_adv), .i_c(r_d), .o_v(w_fw)
    );

    lavm_cross u_cross_lf (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_upn), .i_b(w_fw), .o_c(w_cl)
    );

    lavm_norm #(.IN_W(CROSS_W)) u_norm_lf (
        .i_clk(i_clk), .i_en(w_adv), .i_c(w_cl), .o_v(w_lf)
    );

    lavm_delay #(.W(3*AXIS_W), .DEPTH(D1)) u_dly_fw_a (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_fw), .o_q(w_fw_a)
    );

    lavm_cross u_cross_cu (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_fw_a), .i_b(w_lf), .o_c(w_cu)
    );

    lavm_norm #(.IN_W(CROSS_W)) u_norm_cu (
        .i_clk(i_clk), .i_en(w_adv), .i_c(w_cu), .o_v(w_cu2)
    );

    lavm_delay #(.W(3*AXIS_W), .DEPTH(D1)) u_dly_fw_b (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_fw_a), .o_q(w_fw_b)
    );

    lavm_delay #(.W(3*AXIS_W), .DEPTH(D1)) u_dly_lf_b (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_lf), .o_q(w_lf_b)
    );

    lavm_delay #(.W(3*CW), .DEPTH(DE)) u_dly_eye (
        .i_clk(i_clk), .i_en(w_adv), .i_d(r_eye), .o_q(w_eye_b)
    );

    lavm_xlate #(.CW(CW)) u_xlate_lf (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_lf_b), .i_p(w_eye_b), .o_t(w_sh_lf)
    );

    lavm_xlate #(.CW(CW)) u_xlate_cu (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_cu2), .i_p(w_eye_b), .o_t(w_sh_cu)
    );

    lavm_xlate #(.CW(CW)) u_xlate_fw (
        .i_clk(i_clk), .i_en(w_adv), .i_a(w_fw_b), .i_p(w_eye_b), .o_t(w_sh_fw)
    );

    lavm_delay #(.W(3*AXIS_W), .DEPTH(XLATE_LAT)) u_dly_lf_o (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_lf_b), .o_q(w_lf_o)
    );

    lavm_delay #(.W(3*AXIS_W), .DEPTH(XLATE_LAT)) u_dly_cu_o (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_cu2), .o_q(w_cu_o)
    );

    lavm_delay #(.W(3*AXIS_W), .DEPTH(XLATE_LAT)) u_dly_fw_o (
        .i_clk(i_clk), .i_en(w_adv), .i_d(w_fw_b), .o_q(w_fw_o)
    );

    assign m_axis_tdata = {w_sh_fw, w_sh_cu, w_sh_lf, w_fw_o, w_cu_o, w_lf_o};

endmodule
